### rtl/pdsd_pkg.sv
// ----------------------------------------------------------------------------
// pdsd_pkg
// Shared types and constants for the packed delta sample decoder.
// ----------------------------------------------------------------------------
package pdsd_pkg;

  localparam int WORD_BITS  = 32;
  localparam int PAIR_BITS  = 64;
  localparam int WIDTH_BITS = 6;   // delta_width register
  localparam int CFG_IDX_BITS = 1;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [PAIR_BITS-1:0]  pair_t;
  typedef logic [WIDTH_BITS-1:0] width_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DELTA_WIDTH  = 1'b0,
    CFG_SAMPLE_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DEC  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  localparam width_t WIDTH_RESET = width_t'(16);
  localparam width_t WIDTH_MAX   = width_t'(WORD_BITS);

endpackage

### rtl/pdsd_in_if.sv
// ----------------------------------------------------------------------------
// pdsd_in_if
// Input stream channel: packed delta words with end-of-buffer flag.
// ----------------------------------------------------------------------------
interface pdsd_in_if import pdsd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t packed_word;
  logic  last_word;

  modport source (output valid, output packed_word, output last_word, input ready);
  modport sink   (input valid, input packed_word, input last_word, output ready);
endinterface

### rtl/pdsd_out_if.sv
// ----------------------------------------------------------------------------
// pdsd_out_if
// Result stream channel: decoded words with end-of-buffer flag.
// ----------------------------------------------------------------------------
interface pdsd_out_if import pdsd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t decoded_word;
  logic  final_word;

  modport source (output valid, output decoded_word, output final_word, input ready);
  modport sink   (input valid, input decoded_word, input final_word, output ready);
endinterface

### rtl/packed_delta_sample_decoder_top.sv
// ----------------------------------------------------------------------------
// packed_delta_sample_decoder_top
// Replaces MSB-first packed deltas with running sums modulo 2^width,
// one word of lag so straddling samples complete.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_if   | in  | valid/ready        | packed_word[31:0], last_word
//  out_if  | out | valid/ready        | decoded_word[31:0], final_word
//  cfg_*   | in  | cfg_we (no ready)  | cfg_index[0], cfg_wdata[31:0]
//
//  One transaction at a time. A word that pairs with the held word is
//  accepted, decoded in the shared shift/add unit sample by sample (up to
//  32 samples start in the held word) and then loaded into the output
//  register; a final word adds a second pass for the flush word.
//  Output register decouples the result side; a stall on out_if holds the
//  sequencer in its emit step. Synchronous active-low reset, no clear pass.
// ----------------------------------------------------------------------------
module packed_delta_sample_decoder_top import pdsd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  pdsd_in_if.sink                 in_if,
  pdsd_out_if.source              out_if,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  word_t                   cfg_wdata
);

  // configuration
  width_t delta_width_r;
  word_t  sample_count_r;

  // decode state
  state_t state_r, state_nxt;
  pair_t  cat_r, cat_nxt;
  word_t  held_word_r, held_word_nxt;
  logic   have_held_r, have_held_nxt;
  word_t  running_sum_r, running_sum_nxt;
  width_t bit_offset_r, bit_offset_nxt;
  word_t  samples_left_r, samples_left_nxt;
  logic   flush_r, flush_nxt;       // current pass is the final flush pass
  logic   last_pend_r, last_pend_nxt;

  // output register
  logic   out_valid_r, out_valid_nxt;
  word_t  out_word_r, out_word_nxt;
  logic   out_final_r, out_final_nxt;

  logic   in_acc;
  logic   emit_go;
  width_t eff_n;
  word_t  mask;
  width_t sh;
  pair_t  shifted;
  word_t  delta;
  word_t  sum;

  assign in_if.ready         = (state_r == ST_IDLE);
  assign in_acc              = in_if.valid && in_if.ready;
  assign emit_go             = (state_r == ST_EMIT) && (!out_valid_r || out_if.ready);
  assign out_if.valid        = out_valid_r;
  assign out_if.decoded_word = out_word_r;
  assign out_if.final_word   = out_final_r;

  // shared shift / add unit: one sample per cycle
  always_comb begin
    eff_n   = (delta_width_r > WIDTH_MAX) ? WIDTH_MAX : delta_width_r;
    mask    = (eff_n == WIDTH_MAX) ? '1 : ((word_t'(1) << eff_n) - word_t'(1));
    sh      = width_t'(PAIR_BITS) - bit_offset_r - eff_n;   // 1..63
    shifted = cat_r >> sh;
    delta   = shifted[WORD_BITS-1:0] & mask;
    sum     = (running_sum_r + delta) & mask;
  end

  always_comb begin
    state_nxt        = state_r;
    cat_nxt          = cat_r;
    held_word_nxt    = held_word_r;
    have_held_nxt    = have_held_r;
    running_sum_nxt  = running_sum_r;
    bit_offset_nxt   = bit_offset_r;
    samples_left_nxt = samples_left_r;
    flush_nxt        = flush_r;
    last_pend_nxt    = last_pend_r;
    out_word_nxt     = out_word_r;
    out_final_nxt    = out_final_r;
    out_valid_nxt    = out_valid_r && !out_if.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!have_held_r) begin
            samples_left_nxt = sample_count_r;
            running_sum_nxt  = '0;
            bit_offset_nxt   = '0;
            held_word_nxt    = in_if.packed_word;
            have_held_nxt    = 1'b1;
            if (in_if.last_word) begin
              cat_nxt   = {in_if.packed_word, word_t'(0)};
              flush_nxt = 1'b1;
              state_nxt = ST_DEC;
            end
          end else begin
            cat_nxt       = {held_word_r, in_if.packed_word};
            flush_nxt     = 1'b0;
            last_pend_nxt = in_if.last_word;
            state_nxt     = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        if (eff_n == '0) begin
          samples_left_nxt = '0;
          state_nxt        = ST_EMIT;
        end else if (samples_left_r != '0 && bit_offset_r < width_t'(WORD_BITS)) begin
          running_sum_nxt  = sum;
          cat_nxt          = (cat_r & ~({word_t'(0), mask} << sh)) |
                             ({word_t'(0), sum} << sh);
          bit_offset_nxt   = bit_offset_r + eff_n;
          samples_left_nxt = samples_left_r - word_t'(1);
        end else begin
          if (bit_offset_r >= width_t'(WORD_BITS))
            bit_offset_nxt = bit_offset_r - width_t'(WORD_BITS);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = cat_r[PAIR_BITS-1:WORD_BITS];
          out_final_nxt = flush_r;
          if (flush_r) begin
            held_word_nxt    = '0;
            have_held_nxt    = 1'b0;
            samples_left_nxt = '0;
            bit_offset_nxt   = '0;
            state_nxt        = ST_IDLE;
          end else begin
            held_word_nxt = cat_r[WORD_BITS-1:0];
            if (last_pend_r) begin
              cat_nxt   = {cat_r[WORD_BITS-1:0], word_t'(0)};
              flush_nxt = 1'b1;
              state_nxt = ST_DEC;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      delta_width_r  <= WIDTH_RESET;
      sample_count_r <= word_t'(1);
      held_word_r    <= '0;
      have_held_r    <= 1'b0;
      running_sum_r  <= '0;
      bit_offset_r   <= '0;
      samples_left_r <= '0;
      flush_r        <= 1'b0;
      last_pend_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      held_word_r    <= held_word_nxt;
      have_held_r    <= have_held_nxt;
      running_sum_r  <= running_sum_nxt;
      bit_offset_r   <= bit_offset_nxt;
      samples_left_r <= samples_left_nxt;
      flush_r        <= flush_nxt;
      last_pend_r    <= last_pend_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_DELTA_WIDTH:  delta_width_r  <= cfg_wdata[WIDTH_BITS-1:0];
          CFG_SAMPLE_COUNT: sample_count_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cat_r       <= cat_nxt;
    out_word_r  <= out_word_nxt;
    out_final_r <= out_final_nxt;
  end

`ifndef SYNTHESIS
  // bit offset is always folded back into the current word between passes
  a_offset_folded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (bit_offset_r < width_t'(WORD_BITS)))
    else $error("bit offset not folded at idle");

  // a fresh buffer starts at bit zero
  a_fresh_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !have_held_r) |-> (bit_offset_r == '0))
    else $error("nonzero offset without a held word");

  // the flush transaction closes the buffer
  a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && flush_r) |=> (!have_held_r && state_r == ST_IDLE && out_final_r))
    else $error("flush did not close buffer");

  // a pass through the decode unit always ends in an emit
  a_dec_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEC && state_nxt != ST_DEC) |=> (state_r == ST_EMIT))
    else $error("decode pass left without emit");
`endif

endmodule

### verif/packed_delta_sample_decoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_delta_sample_decoder_top_tb
// Self-checking bench for the packed delta decoder. A short table of
// directed buffers (reset values, width and count extremes, pass-through
// cases) is followed by random buffers under changing settings. Every
// accepted word is run through a local running-sum decoder, and each
// decoded transaction is compared in order against its predictions.
// ----------------------------------------------------------------------------
module packed_delta_sample_decoder_top_tb;
  import pdsd_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 100;   // two passes of up to 32 samples each
  localparam int RANDOM_ITEMS = 1550;
  localparam int IDLE_PCT     = 16;
  localparam int CALM_FIRST   = 500;
  localparam int CALM_LAST    = 800;
  localparam int N_DIRECTED   = 23;

  typedef struct packed {
    word_t data;
    logic  fin;
  } dec_word_t;

  // directed stimulus; rows with lit set carry results read off by hand
  typedef struct packed {
    bit         set_cfg;
    width_t     width;
    word_t      count;
    word_t      word;
    logic       last;
    bit         lit;
    logic [1:0] n_lit;
    word_t      lit0;
    word_t      lit1;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  word_t cfg_wdata;
  bit calm;
  int errors;
  int sent;

  pdsd_in_if  in_if ();
  pdsd_out_if out_if ();

  packed_delta_sample_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // decoder state mirror
  width_t cur_width  = WIDTH_RESET;
  word_t  cur_count  = 32'd1;
  word_t  hold_word  = '0;
  bit     hold_valid = 1'b0;
  word_t  acc_sum    = '0;
  width_t bit_pos    = '0;
  word_t  left_cnt   = '0;

  dec_word_t decoded_q [$];

  row_t directed_rows [N_DIRECTED] = '{
    // reset settings: width 16, one sample
    '{1'b0, 6'd0,  32'd0,        32'h0001_0002, 1'b1, 1'b1, 2'd1, 32'h0001_0002, 32'h0},
    // full width, maximum count; sum wraps to zero
    '{1'b1, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 2'd0, 32'h0, 32'h0},
    '{1'b0, 6'd0,  32'd0,        32'h0000_0001, 1'b1, 1'b1, 2'd2, 32'hFFFF_FFFF, 32'h0},
    // zero width passes through
    '{1'b1, 6'd0,  32'd5,        32'hDEAD_BEEF, 1'b1, 1'b1, 2'd1, 32'hDEAD_BEEF, 32'h0},
    // width above 32 clamps
    '{1'b1, 6'd63, 32'd2,        32'h0000_0005, 1'b0, 1'b1, 2'd0, 32'h0, 32'h0},
    '{1'b0, 6'd0,  32'd0,        32'h0000_0003, 1'b1, 1'b1, 2'd2, 32'h0000_0005, 32'h8},
    // zero count passes through
    '{1'b1, 6'd1,  32'd0,        32'hA5A5_A5A5, 1'b1, 1'b1, 2'd1, 32'hA5A5_A5A5, 32'h0},
    // single-bit samples toggle the sum
    '{1'b1, 6'd1,  32'd32,       32'hFFFF_FFFF, 1'b1, 1'b1, 2'd1, 32'hAAAA_AAAA, 32'h0},
    '{1'b1, 6'd32, 32'd1,        32'h0000_0000, 1'b1, 1'b1, 2'd1, 32'h0, 32'h0},
    // straddling samples
    '{1'b1, 6'd24, 32'd3,        32'h1234_5678, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b0, 6'd0,  32'd0,        32'h9ABC_DEF0, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b0, 6'd0,  32'd0,        32'h0FED_CBA9, 1'b1, 1'b0, 2'd0, 32'h0, 32'h0},
    // last sample runs past the buffer end
    '{1'b1, 6'd24, 32'd10,       32'h8000_0001, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b0, 6'd0,  32'd0,        32'h7FFF_FFFE, 1'b1, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b1, 6'd7,  32'd100,      32'h0000_0000, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b0, 6'd0,  32'd0,        32'hFFFF_FFFF, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b0, 6'd0,  32'd0,        32'h5555_5555, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b0, 6'd0,  32'd0,        32'hFFFF_FFFF, 1'b1, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b1, 6'd31, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b0, 6'd0,  32'd0,        32'h8000_0000, 1'b1, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b1, 6'd33, 32'd1,        32'h0000_0001, 1'b1, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b1, 6'd5,  32'd7,        32'hC0FF_EE11, 1'b0, 1'b0, 2'd0, 32'h0, 32'h0},
    '{1'b0, 6'd0,  32'd0,        32'h0000_0000, 1'b1, 1'b0, 2'd0, 32'h0, 32'h0}
  };

  // decode every sample that starts in hi, lo supplies straddling bits
  function automatic pair_t fold_pair(word_t hi, word_t lo);
    pair_t cat;
    pair_t mask;
    pair_t sum;
    int    n;
    int    sh;
    cat = {hi, lo};
    n = (int'(cur_width) > WORD_BITS) ? WORD_BITS : int'(cur_width);
    if (n == 0) begin
      left_cnt = '0;
      return cat;
    end
    mask = (n >= WORD_BITS) ? pair_t'(32'hFFFF_FFFF) : ((pair_t'(1) << n) - pair_t'(1));
    while (left_cnt != 0 && int'(bit_pos) < WORD_BITS) begin
      sh = PAIR_BITS - int'(bit_pos) - n;
      sum = (pair_t'(acc_sum) + ((cat >> sh) & mask)) & mask;
      acc_sum = sum[WORD_BITS-1:0];
      cat = (cat & ~(mask << sh)) | (sum << sh);
      bit_pos = width_t'(int'(bit_pos) + n);
      left_cnt = left_cnt - 1;
    end
    if (int'(bit_pos) >= WORD_BITS) bit_pos = width_t'(int'(bit_pos) - WORD_BITS);
    return cat;
  endfunction

  // returns how many decoded words this input word releases
  function automatic int decode_word(input word_t w, input logic l,
                                     output dec_word_t r0, output dec_word_t r1);
    pair_t cat;
    int    cnt;
    cnt = 0;
    r0 = '0;
    r1 = '0;
    if (!hold_valid) begin
      left_cnt   = cur_count;
      acc_sum    = '0;
      bit_pos    = '0;
      hold_word  = w;
      hold_valid = 1'b1;
    end else begin
      cat = fold_pair(hold_word, w);
      r0 = '{data: cat[PAIR_BITS-1:WORD_BITS], fin: 1'b0};
      hold_word = cat[WORD_BITS-1:0];
      cnt = 1;
    end
    if (l) begin
      cat = fold_pair(hold_word, '0);
      if (cnt == 0) r0 = '{data: cat[PAIR_BITS-1:WORD_BITS], fin: 1'b1};
      else          r1 = '{data: cat[PAIR_BITS-1:WORD_BITS], fin: 1'b1};
      cnt++;
      hold_word  = '0;
      hold_valid = 1'b0;
      left_cnt   = '0;
      bit_pos    = '0;
    end
    return cnt;
  endfunction

  task automatic push_word(word_t w, logic l, bit lit, logic [1:0] n_lit,
                           word_t lit0, word_t lit1);
    dec_word_t r0;
    dec_word_t r1;
    int        cnt;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.packed_word <= w;
    in_if.last_word   <= l;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    cnt = decode_word(w, l, r0, r1);
    if (lit) begin
      cnt = int'(n_lit);
      r0 = '{data: lit0, fin: l && cnt == 1};
      r1 = '{data: lit1, fin: l};
    end
    if (cnt > 0) decoded_q.push_back(r0);
    if (cnt > 1) decoded_q.push_back(r1);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(width_t width, word_t count);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DELTA_WIDTH;
    cfg_wdata <= word_t'(width);
    @(posedge clk);
    cfg_index <= CFG_SAMPLE_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_width = width;
    cur_count = count;
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    dec_word_t exp_w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (decoded_q.size() == 0) begin
        $error("decoded_word: no transaction expected, got %h", out_if.decoded_word);
        errors++;
      end else begin
        exp_w = decoded_q.pop_front();
        if (out_if.decoded_word !== exp_w.data) begin
          $error("decoded_word: expected %h, got %h", exp_w.data, out_if.decoded_word);
          errors++;
        end
        if (out_if.final_word !== exp_w.fin) begin
          $error("final_word: expected %b, got %b", exp_w.fin, out_if.final_word);
          errors++;
        end
      end
    end
  end

  initial begin
    int     nw;
    int     eff;
    int     cap;
    width_t width;
    word_t  count;
    word_t  w;
    errors = 0;
    sent   = 0;
    calm   <= 1'b0;
    rst_n  <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DELTA_WIDTH;
    cfg_wdata <= '0;
    in_if.valid       <= 1'b0;
    in_if.packed_word <= '0;
    in_if.last_word   <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_cfg) begin
        settle();
        write_cfg(directed_rows[i].width, directed_rows[i].count);
      end
      push_word(directed_rows[i].word, directed_rows[i].last, directed_rows[i].lit,
                directed_rows[i].n_lit, directed_rows[i].lit0, directed_rows[i].lit1);
    end

    while (sent < RANDOM_ITEMS) begin
      nw = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
      if (sent == 0 || $urandom_range(2) == 0) begin
        case ($urandom_range(19))
          0:       width = '0;
          1:       width = width_t'($urandom_range(63, 33));
          2:       width = width_t'(1);
          3:       width = WIDTH_MAX;
          default: width = width_t'($urandom_range(32, 1));
        endcase
        eff = (int'(width) == 0) ? 1 : ((int'(width) > WORD_BITS) ? WORD_BITS : int'(width));
        cap = nw * WORD_BITS / eff;
        case ($urandom_range(9))
          0:       count = '0;
          1:       count = 32'hFFFF_FFFF;
          2:       count = $urandom();
          3:       count = word_t'(cap + $urandom_range(3, 1));  // runs past the end
          default: count = word_t'($urandom_range(cap, 1));
        endcase
        settle();
        write_cfg(width, count);
      end
      for (int k = 0; k < nw; k++) begin
        calm <= (sent >= CALM_FIRST && sent < CALM_LAST);
        case ($urandom_range(15))
          0:       w = '0;
          1:       w = '1;
          default: w = $urandom();
        endcase
        push_word(w, k == nw - 1, 1'b0, 2'd0, '0, '0);
        sent++;
      end
    end

    settle();
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("packed_delta_sample_decoder_top regression: pass");
    end else begin
      $display("packed_delta_sample_decoder_top regression: fail");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("packed_delta_sample_decoder_top regression: fail");
    $finish;
  end

endmodule
